FILE: hw/rtl/jse_pkg.sv
// Shared types, character constants and helper functions for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_SHIFT = 8'h57;   // 'a' minus ten
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LET_B   = 8'h62;
    localparam logic [7:0] CH_LET_F   = 8'h66;
    localparam logic [7:0] CH_LET_N   = 8'h6E;
    localparam logic [7:0] CH_LET_R   = 8'h72;
    localparam logic [7:0] CH_LET_T   = 8'h74;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_PLAIN,
        BODY_SHORT,
        BODY_UNICODE
    } body_kind_t;

    typedef struct packed {
        logic       open_q;
        logic       close_q;
        body_kind_t kind;
        logic [7:0] data;
    } esc_desc_t;

    function automatic logic [2:0] body_len(input body_kind_t kind);
        logic [2:0] len;
        begin
            unique case (kind)
                BODY_NONE:    len = 3'd0;
                BODY_PLAIN:   len = 3'd1;
                BODY_SHORT:   len = 3'd2;
                BODY_UNICODE: len = 3'd6;
                default:      len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        begin
            if (nib < 4'd10)
                ch = CH_ZERO + {4'b0, nib};
            else
                ch = CH_A_SHIFT + {4'b0, nib};
            return ch;
        end
    endfunction

endpackage

FILE: hw/rtl/jse_front.sv
// Front end: accept input items, classify each byte and track the open-string state.
`timescale 1ns / 1ps

module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_string,
    input  logic       empty_string,
    input  logic       q_full,
    output logic       push,
    output esc_desc_t  push_desc,
    output logic       string_open
);

    logic inside_reg;
    logic inside_next;

    assign in_stall    = q_full;
    assign push        = in_valid && !q_full;
    assign string_open = inside_reg;

    always_comb
    begin
        push_desc.open_q  = !inside_reg;
        push_desc.close_q = end_of_string || empty_string;
        push_desc.data    = char_byte;
        push_desc.kind    = BODY_PLAIN;
        if (empty_string)
        begin
            push_desc.kind = BODY_NONE;
        end
        else
        begin
            unique case (char_byte)
                CH_QUOTE:  push_desc.kind = BODY_SHORT;
                CH_BSLASH: push_desc.kind = BODY_SHORT;
                CH_BS:
                begin
                    push_desc.kind = BODY_SHORT;
                    push_desc.data = CH_LET_B;
                end
                CH_FF:
                begin
                    push_desc.kind = BODY_SHORT;
                    push_desc.data = CH_LET_F;
                end
                CH_LF:
                begin
                    push_desc.kind = BODY_SHORT;
                    push_desc.data = CH_LET_N;
                end
                CH_CR:
                begin
                    push_desc.kind = BODY_SHORT;
                    push_desc.data = CH_LET_R;
                end
                CH_TAB:
                begin
                    push_desc.kind = BODY_SHORT;
                    push_desc.data = CH_LET_T;
                end
                default:
                begin
                    if (char_byte < CTRL_LIMIT)
                        push_desc.kind = BODY_UNICODE;
                    else
                        push_desc.kind = BODY_PLAIN;
                end
            endcase
        end
    end

    always_comb
    begin
        inside_next = inside_reg;
        if (push)
            inside_next = !(end_of_string || empty_string);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else
            inside_reg <= inside_next;
    end

endmodule

FILE: hw/rtl/jse_fifo.sv
// Short descriptor queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module jse_fifo
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  esc_desc_t push_desc,
    input  logic      pop,
    output esc_desc_t pop_desc,
    output logic      full,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    esc_desc_t       slots [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_desc = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_desc;
    end

endmodule

FILE: hw/rtl/jse_back.sv
// Output sequencer: expand each descriptor into quoted, escaped bytes one a cycle while the receiver does not stall.
`timescale 1ns / 1ps

module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  esc_desc_t  head,
    input  logic       q_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_out
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       load;
    logic       fire;
    logic       done;
    logic [3:0] total;
    logic [2:0] len;
    logic [2:0] pos;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load = !valid_reg || !out_stall;
    assign fire = load && !q_empty;
    assign len  = body_len(head.kind);
    assign total = {3'b0, head.open_q} + {1'b0, len} + {3'b0, head.close_q};
    assign done = ({1'b0, idx_reg} + 4'd1) == total;
    assign pos  = idx_reg - {2'b0, head.open_q};
    assign pop  = fire && done;

    always_comb
    begin
        cur_last = 1'b0;
        cur_byte = CH_QUOTE;
        if (head.open_q && idx_reg == 3'd0)
        begin
            cur_byte = CH_QUOTE;
        end
        else if (pos < len)
        begin
            unique case (head.kind)
                BODY_PLAIN:
                    cur_byte = head.data;
                BODY_SHORT:
                    cur_byte = (pos == 3'd0) ? CH_BSLASH : head.data;
                BODY_UNICODE:
                begin
                    case (pos)
                        3'd0:    cur_byte = CH_BSLASH;
                        3'd1:    cur_byte = CH_U;
                        3'd4:    cur_byte = hex_digit(head.data[7:4]);
                        3'd5:    cur_byte = hex_digit(head.data[3:0]);
                        default: cur_byte = CH_ZERO;
                    endcase
                end
                default:
                    cur_byte = CH_QUOTE;
            endcase
        end
        else
        begin
            // Past the body: closing quote ends the string.
            cur_byte = CH_QUOTE;
            cur_last = 1'b1;
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            idx_next   = done ? 3'd0 : idx_reg + 3'd1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last_out  = last_reg;

endmodule

FILE: hw/rtl/json_string_escaper.sv
// Top level of the JSON string escaper: front end, descriptor queue and output sequencer.
`timescale 1ns / 1ps

// Streams a string in, one byte per item, and streams it out as a quoted JSON string
// literal, one byte per output item. An opening quote goes out before the first byte of
// a string and a closing quote, flagged by last_out, after the byte marked end_of_string.
// An item with empty_string set emits two quotes, or only the closing quote if a string
// is already open. Quote and backslash become a backslash pair, backspace, form feed,
// newline, CR and tab become their two-character escapes, other bytes below 32 become
// \u00xx in lowercase hex, and everything else passes through unchanged. The output side
// produces one byte per cycle from its output register while out_stall is low; an item
// yields as many bytes as it produces: 1 for a plain byte, 2 for a short escape, 6 for a
// \u escape, plus one for each quote it carries. The input side takes one item per cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room, so bursts of plain text flow at one
// byte per cycle and escapes stall the input only once the queue has filled.

module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_string,
    input  logic       empty_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_out
);

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    logic      string_open;
    esc_desc_t push_desc;
    esc_desc_t head_desc;

    // Classify each accepted byte into a descriptor and track the open quote.
    jse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .end_of_string (end_of_string),
        .empty_string  (empty_string),
        .q_full        (q_full),
        .push          (push),
        .push_desc     (push_desc),
        .string_open   (string_open)
    );

    // Decouple the two sides so escapes drain while new bytes arrive.
    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Expand the head descriptor into output bytes, one a cycle while the receiver does not stall.
    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_desc),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_out  (last_out)
    );

    // The closing-quote flag only ever rides on a quote byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_out) |-> (out_byte == CH_QUOTE))
        else $error("last_out set on a byte that is not a quote");

    // Ending or emptying a string leaves no string open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (end_of_string || empty_string)) |=> !string_open)
        else $error("string still open after end or empty item");

    // The sequencer never retires a descriptor from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !pop)
        else $error("pop from empty descriptor queue");

endmodule

FILE: tb/sv/tb_json_string_escaper.sv
// Self-checking testbench for the JSON string escaper: queued driver, predictor and checker.
`timescale 1ns / 1ps

module tb_json_string_escaper;
    import jse_pkg::*;

    // One input item: a raw string byte with its two flags.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       empty;
    } char_item_t;

    // One output item: a byte of the quoted JSON text and its closing flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } json_byte_t;

    // Upper bound on the length of the whole run before it times out.
    localparam int CYCLE_LIMIT = 400000;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_HOLD   = 300;
    // Cycles to watch for stray output after the last expected byte.
    localparam int DRAIN_WAIT  = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_byte = 8'h00;
    logic       end_of_string = 1'b0;
    logic       empty_string = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_out;

    char_item_t pending_chars[$];   // items waiting to be offered
    json_byte_t json_expected[$];   // escaped bytes still to come out

    logic       string_open = 1'b0; // predictor copy of the block's open-string flag
    logic       in_taken = 1'b0;    // item on the input was accepted at the last edge
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic       recv_hold_req = 1'b0;
    logic       recv_hold_done = 1'b0;
    int         hold_left = 0;
    int         errors = 0;
    int         cycles = 0;
    char_item_t next_item;
    json_byte_t want;

    json_string_escaper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .end_of_string (end_of_string),
        .empty_string  (empty_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_out      (last_out)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        if (nib > 4'd9)
            return "a" + {4'b0000, nib} - 8'd10;
        return "0" + {4'b0000, nib};
    endfunction

    task automatic queue_json(input logic [7:0] ch, input logic last);
        json_expected.push_back({ch, last});
    endtask

    // Work out the JSON bytes one accepted item produces and queue them.
    task automatic predict_escape(input logic [7:0] c, input logic eos, input logic empty);
        logic [7:0] letter;
        letter = 8'h00;
        // An empty-string item wins over end_of_string and ignores the byte.
        if (empty)
        begin
            if (!string_open)
                queue_json(CH_QUOTE, 1'b0);
            queue_json(CH_QUOTE, 1'b1);
            string_open = 1'b0;
        end
        else
        begin
            if (!string_open)
                queue_json(CH_QUOTE, 1'b0);
            case (c)
                CH_QUOTE:  letter = CH_QUOTE;
                CH_BSLASH: letter = CH_BSLASH;
                CH_BS:     letter = CH_LET_B;
                CH_FF:     letter = CH_LET_F;
                CH_LF:     letter = CH_LET_N;
                CH_CR:     letter = CH_LET_R;
                CH_TAB:    letter = CH_LET_T;
                default:   letter = 8'h00;
            endcase
            if (letter != 8'h00)
            begin
                queue_json(CH_BSLASH, 1'b0);
                queue_json(letter, 1'b0);
            end
            else if (c < CTRL_LIMIT)
            begin
                // Remaining control bytes, zero included, go out as a \u00xx escape.
                queue_json(CH_BSLASH, 1'b0);
                queue_json(CH_U, 1'b0);
                queue_json(CH_ZERO, 1'b0);
                queue_json(CH_ZERO, 1'b0);
                queue_json(hex_ascii(c[7:4]), 1'b0);
                queue_json(hex_ascii(c[3:0]), 1'b0);
            end
            else
            begin
                queue_json(c, 1'b0);
            end
            if (eos)
            begin
                queue_json(CH_QUOTE, 1'b1);
                string_open = 1'b0;
            end
            else
            begin
                string_open = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_char(input logic [7:0] ch, input logic eos, input logic empty);
        pending_chars.push_back({ch, eos, empty});
    endtask

    // Pick a string byte, weighted toward the escape classes.
    function automatic logic [7:0] pick_char();
        int         k;
        logic [7:0] ch;
        k = $urandom_range(99);
        if (k < 35)
        begin
            ch = 8'($urandom_range(126, 32));
        end
        else if (k < 55)
        begin
            case ($urandom_range(6))
                0:       ch = CH_QUOTE;
                1:       ch = CH_BSLASH;
                2:       ch = CH_BS;
                3:       ch = CH_FF;
                4:       ch = CH_LF;
                5:       ch = CH_CR;
                default: ch = CH_TAB;
            endcase
        end
        else if (k < 75)
        begin
            ch = 8'($urandom_range(31, 0));
        end
        else
        begin
            ch = 8'($urandom_range(255, 0));
        end
        return ch;
    endfunction

    // Queue about n items: mostly whole strings with random content, some
    // empty strings, and some raw noise that opens or cuts strings short.
    task automatic add_random_strings(input int n);
        int         made;
        int         len;
        int         k;
        logic [7:0] rb;
        logic       r_eos;
        logic       r_empty;
        made = 0;
        while (made < n)
        begin
            k = $urandom_range(99);
            if (k < 12)
            begin
                rb = 8'($urandom);
                r_eos = 1'($urandom);
                r_empty = 1'($urandom);
                add_char(rb, r_eos, r_empty);
                made++;
            end
            else if (k < 20)
            begin
                rb = 8'($urandom);
                r_eos = 1'($urandom);
                add_char(rb, r_eos, 1'b1);
                made++;
            end
            else
            begin
                len = $urandom_range(10, 1);
                for (int i = 0; i < len; i++)
                    add_char(pick_char(), (i == len - 1), 1'b0);
                made += len;
            end
        end
    endtask

    // Hold until every queued item is taken and every expected byte has come.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || in_valid || json_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending item at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            // Advance only once the current item is gone; a stalled item holds.
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_chars.pop_front();
                in_valid      <= 1'b1;
                char_byte     <= next_item.ch;
                end_of_string <= next_item.eos;
                empty_string  <= next_item.empty;
            end
            else
            begin
                // Drive junk on the payload while nothing is offered.
                in_valid      <= 1'b0;
                char_byte     <= 8'($urandom);
                end_of_string <= 1'($urandom);
                empty_string  <= 1'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off counted here
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                recv_hold_done <= 1'b1;
        end
        else if (recv_hold_req && !recv_hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker and input tracking at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            // Check first, so a byte can never be matched against its own item.
            if (out_valid && !out_stall)
            begin
                if (json_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output: expected none, actual byte %02h last %0b",
                             $time, out_byte, last_out);
                end
                else
                begin
                    want = json_expected.pop_front();
                    if (want.ch !== out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.ch, out_byte);
                    end
                    if (want.last !== last_out)
                    begin
                        errors++;
                        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                                 $time, want.last, last_out);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_escape(char_byte, end_of_string, empty_string);
            in_taken <= in_valid && !in_stall;
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes still expected", $time, json_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sender idles a little, receiver most of the time.
        send_idle_pct = 19;
        recv_idle_pct = 88;

        // Empty string with every flag set and a byte that must be ignored.
        add_char(8'hFF, 1'b1, 1'b1);
        // Byte zero alone in a string.
        add_char(8'h00, 1'b1, 1'b0);
        // One string through every escape class and the byte extremes.
        add_char(CH_QUOTE, 1'b0, 1'b0);
        add_char(CH_BSLASH, 1'b0, 1'b0);
        add_char(CH_BS, 1'b0, 1'b0);
        add_char(CH_FF, 1'b0, 1'b0);
        add_char(CH_LF, 1'b0, 1'b0);
        add_char(CH_CR, 1'b0, 1'b0);
        add_char(CH_TAB, 1'b0, 1'b0);
        add_char(8'h1F, 1'b0, 1'b0);
        add_char(8'h01, 1'b0, 1'b0);
        add_char(8'h20, 1'b0, 1'b0);
        add_char(8'h7E, 1'b0, 1'b0);
        add_char(8'h7F, 1'b0, 1'b0);
        add_char(8'h80, 1'b0, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0);
        // Empty string while a string is open closes it.
        add_char(8'h41, 1'b0, 1'b0);
        add_char(8'h00, 1'b0, 1'b1);
        // Empty string with no string open and end flag low.
        add_char(8'h5A, 1'b0, 1'b1);
        // Two control bytes needing upper hex digits.
        add_char(8'h1B, 1'b0, 1'b0);
        add_char(8'h10, 1'b1, 1'b0);

        add_random_strings(130);
        // Wait until every queued item is taken and every expected byte is out.
        wait_drained();

        // Phase two: the other way round.
        send_idle_pct = 88;
        recv_idle_pct = 19;
        add_random_strings(130);
        wait_drained();

        // Phase three: no idling, with one long receiver hold-off while the
        // sender keeps offering, so the block fills and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_strings(140);
        recv_hold_req = 1'b1;
        wait (recv_hold_done);
        recv_hold_req = 1'b0;
        wait_drained();

        // Watch for stray bytes after the last one expected.
        repeat (DRAIN_WAIT) @(posedge clk);
        if (json_expected.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected bytes never came", $time, json_expected.size());
        end

        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_fifo.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper.sv
tb/sv/tb_json_string_escaper.sv
